// ----- rtl/core/bsfp_pkg.sv -----
// ----------------------------------------------------------------------------
// bsfp_pkg: shared types and constants for the byte stuffing framer
// kinds of output byte, slot positions of one request and register reset values
// ----------------------------------------------------------------------------
package bsfp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned NUM_SLOT = 5;
  localparam int unsigned SLOT_W   = $clog2(NUM_SLOT);

  // output byte kinds, as carried on the result channel
  typedef enum logic [1:0] {
    KIND_FLAG    = 2'd0,
    KIND_ESCAPE  = 2'd1,
    KIND_CONTENT = 2'd2,
    KIND_TRAILER = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_FLAG   = 1'b0,
    REG_ESCAPE = 1'b1
  } reg_idx_t;

  // fixed order of the result slots that one input request can produce
  localparam logic [SLOT_W-1:0] SLOT_OPEN    = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_ESCAPE  = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_CONTENT = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_CLOSE   = SLOT_W'(3);
  localparam logic [SLOT_W-1:0] SLOT_TRAILER = SLOT_W'(4);

  localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'd36;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd47;

  typedef logic [NUM_SLOT-1:0] slot_mask_t;

endpackage

// ----- rtl/core/byte_stuff_framer_with_parity.sv -----
// ----------------------------------------------------------------------------
// byte_stuff_framer_with_parity: flag byte stuffing with an xor parity trailer
// turns message bytes into a framed, escaped byte stream with a parity byte
// ----------------------------------------------------------------------------
// Each input request is one message byte with first and last marks, or an
// empty-frame marker. It expands into one to five output bytes: an opening
// flag when marked first, an escape byte when the content byte equals the
// flag or the escape value, the content byte, and a closing flag plus an xor
// parity trailer when marked last. An empty frame gives flag, flag and a zero
// trailer. The input stage holds one request and a five-bit mask of the
// output slots it still owes; whenever the output register is empty or
// being drained, the lowest pending slot is loaded into it. The next
// request is accepted in the same cycle the last output byte of the
// current one is loaded, so there are no dead cycles between requests. The
// output register holds the byte, but in_tready follows out_tready through
// load combinationally. Configuration writes go straight into the flag and
// escape registers and must only happen while the block is idle.
// ----------------------------------------------------------------------------
module byte_stuff_framer_with_parity
  import bsfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  // input request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  input  logic [1:0]  in_tuser,   // [0] first_byte, [1] empty_frame
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,  // run_end
  output logic [2:0]  out_tuser   // [1:0] byte_kind, [2] frame_end
);

  // configuration registers
  logic [BYTE_W-1:0] flag_r, flag_nxt;
  logic [BYTE_W-1:0] esc_r, esc_nxt;

  // input stage: held request and its pending result slots
  logic [BYTE_W-1:0] data_r, data_nxt;
  slot_mask_t        pend_r, pend_nxt;

  // running frame parity
  logic [BYTE_W-1:0] parity_r, parity_nxt;

  // output register
  logic              ovld_r, ovld_nxt;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  kind_t             okind_r, okind_nxt;
  logic              olast_r, olast_nxt;
  logic              oend_r, oend_nxt;

  logic              item_vld;
  logic              in_fire;
  logic              load;
  logic [SLOT_W-1:0] slot;
  slot_mask_t        rest;
  logic              run_done;
  slot_mask_t        new_mask;
  logic              first_in, empty_in, needs_esc;
  logic [BYTE_W-1:0] emit_byte;
  kind_t             emit_kind;

  assign item_vld = |pend_r;

  // output register takes a new byte when empty or being drained this cycle
  assign load = item_vld && (!ovld_r || out_tready);

  // pick the lowest pending slot
  always_comb begin
    slot = SLOT_TRAILER;
    for (int i = NUM_SLOT - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    rest = pend_r;
    rest[slot] = 1'b0;
  end

  assign run_done  = (rest == '0);

  // free for a new request when nothing is held, or the last byte leaves now
  assign in_tready = !item_vld || (load && run_done);
  assign in_fire   = in_tvalid && in_tready;

  // slot mask of an arriving request
  assign first_in  = in_tuser[0];
  assign empty_in  = in_tuser[1];
  assign needs_esc = (in_tdata == flag_r) || (in_tdata == esc_r);

  always_comb begin
    new_mask = '0;
    if (empty_in) begin
      new_mask[SLOT_OPEN]    = 1'b1;
      new_mask[SLOT_CLOSE]   = 1'b1;
      new_mask[SLOT_TRAILER] = 1'b1;
    end else begin
      new_mask[SLOT_OPEN]    = first_in;
      new_mask[SLOT_ESCAPE]  = needs_esc;
      new_mask[SLOT_CONTENT] = 1'b1;
      new_mask[SLOT_CLOSE]   = in_tlast;
      new_mask[SLOT_TRAILER] = in_tlast;
    end
  end

  // byte and kind for the selected slot
  always_comb begin
    case (slot)
      SLOT_OPEN: begin
        emit_byte = flag_r;
        emit_kind = KIND_FLAG;
      end
      SLOT_ESCAPE: begin
        emit_byte = esc_r;
        emit_kind = KIND_ESCAPE;
      end
      SLOT_CONTENT: begin
        emit_byte = data_r;
        emit_kind = KIND_CONTENT;
      end
      SLOT_CLOSE: begin
        emit_byte = flag_r;
        emit_kind = KIND_FLAG;
      end
      default: begin
        // trailer carries the parity folded up to the closing flag
        emit_byte = parity_r;
        emit_kind = KIND_TRAILER;
      end
    endcase
  end

  always_comb begin
    flag_nxt   = flag_r;
    esc_nxt    = esc_r;
    data_nxt   = data_r;
    pend_nxt   = pend_r;
    parity_nxt = parity_r;
    ovld_nxt   = ovld_r;
    obyte_nxt  = obyte_r;
    okind_nxt  = okind_r;
    olast_nxt  = olast_r;
    oend_nxt   = oend_r;

    if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_addr))
        REG_FLAG:   flag_nxt = cfg_wdata;
        REG_ESCAPE: esc_nxt  = cfg_wdata;
        default:    ;
      endcase
    end

    if (ovld_r && out_tready) begin
      ovld_nxt = 1'b0;
    end

    if (load) begin
      ovld_nxt  = 1'b1;
      obyte_nxt = emit_byte;
      okind_nxt = emit_kind;
      olast_nxt = run_done;
      oend_nxt  = (slot == SLOT_TRAILER);
      pend_nxt  = rest;
      // opening flag restarts the frame, trailer clears it
      if (slot == SLOT_OPEN) begin
        parity_nxt = emit_byte;
      end else if (slot == SLOT_TRAILER) begin
        parity_nxt = '0;
      end else begin
        parity_nxt = parity_r ^ emit_byte;
      end
    end

    if (in_fire) begin
      data_nxt = in_tdata;
      pend_nxt = new_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r   <= FLAG_RESET;
      esc_r    <= ESCAPE_RESET;
      pend_r   <= '0;
      parity_r <= '0;
      ovld_r   <= 1'b0;
    end else begin
      flag_r   <= flag_nxt;
      esc_r    <= esc_nxt;
      pend_r   <= pend_nxt;
      parity_r <= parity_nxt;
      ovld_r   <= ovld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    obyte_r <= obyte_nxt;
    okind_r <= okind_nxt;
    olast_r <= olast_nxt;
    oend_r  <= oend_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = {oend_r, okind_r};

  // trailer always closes the frame and ends the request's run
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && okind_r == KIND_TRAILER) |-> (oend_r && out_tlast))
    else $error("trailer without frame end or run end");

  // an escape byte is always followed by its content byte in the same run
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && okind_r == KIND_ESCAPE) |-> !out_tlast)
    else $error("run ended on an escape byte");

  // parity is zero between frames once a trailer has been loaded
  assert property (@(posedge clk) disable iff (!rst_n)
    (load && slot == SLOT_TRAILER) |=> (parity_r == '0))
    else $error("parity not cleared after trailer");

endmodule

// ----- bench/byte_stuff_framer_with_parity_tb.sv -----
// ----------------------------------------------------------------------------
// byte_stuff_framer_with_parity_tb: self-checking bench for the stuffing framer
// predicts every framed byte of each accepted request and checks the stream
// ----------------------------------------------------------------------------
// Each accepted request runs through a local model of the framer. The model
// keeps its own flag, escape and running parity. It queues the bytes that the
// request must produce: opening flag, escape, content, closing flag and parity
// trailer, each with its kind and end marks. A monitor pops the oldest queued
// byte for every result handshake and compares it field by field. The stimulus
// starts with directed frames at the reset markers, equal markers and extreme
// markers. Random phases follow, under several marker settings: mostly
// well-formed frames with content biased toward the marker values, and some
// empty frames, abandoned frames, frames with no opening mark and raw noise.
// Both sides idle at random. One phase holds the receiver off long enough to
// fill the block, and one phase streams with no gaps at all.
// ----------------------------------------------------------------------------
module byte_stuff_framer_with_parity_tb;
  import bsfp_pkg::*;

  // one expected byte of the framed stream
  typedef struct packed {
    logic [7:0] octet;
    kind_t      kind;
    logic       run_end;
    logic       frame_end;
  } framed_byte_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [0:0] cfg_addr;
  logic [7:0] cfg_wdata;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] data_byte
  logic       in_tlast;   // last_byte
  logic [1:0] in_tuser;   // [0] first_byte, [1] empty_frame
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic       out_tlast;  // run_end
  logic [2:0] out_tuser;  // [1:0] byte_kind, [2] frame_end

  // model state: marker registers as written and the running frame parity
  logic [7:0] flag_reg;
  logic [7:0] escape_reg;
  logic [7:0] parity_run;

  framed_byte_t expected_bytes[$];

  int mismatches    = 0;
  int requests_sent = 0;
  int in_gap_max    = 16;  // sender gap drawn from 0 up to this per request
  int out_gap_max   = 16;  // receiver stall drawn from 0 up to this per result
  int hold_cycles   = 0;   // a long receiver hold-off, taken by the sink

  byte_stuff_framer_with_parity dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // framing model
  // ------------------------------------------------------------------------

  // queue one framed byte and fold it into the running parity
  function automatic void emit_byte(input logic [7:0] value_b, input kind_t kind_b);
    framed_byte_t fb;
    fb.octet     = value_b;
    fb.kind      = kind_b;
    fb.run_end   = 1'b0;
    fb.frame_end = (kind_b == KIND_TRAILER);
    expected_bytes.insert(expected_bytes.size(), fb);
    parity_run = parity_run ^ value_b;
  endfunction

  // expected output bytes of one accepted request
  function automatic void predict_stuffing(input logic [7:0] data, input logic first,
                                           input logic last, input logic empty);
    if (empty) begin
      // empty frame drops any partial frame: flag, flag, zero trailer
      parity_run = '0;
      emit_byte(flag_reg, KIND_FLAG);
      emit_byte(flag_reg, KIND_FLAG);
      emit_byte(parity_run, KIND_TRAILER);
      parity_run = '0;
    end else begin
      // an opening flag restarts the parity even inside an unfinished frame
      if (first) begin
        parity_run = '0;
        emit_byte(flag_reg, KIND_FLAG);
      end
      // one escape only, even when flag and escape are the same byte
      if (data == flag_reg || data == escape_reg) begin
        emit_byte(escape_reg, KIND_ESCAPE);
      end
      emit_byte(data, KIND_CONTENT);
      if (last) begin
        emit_byte(flag_reg, KIND_FLAG);
        emit_byte(parity_run, KIND_TRAILER);
        parity_run = '0;
      end
    end
    // the last byte of this request carries the run end mark
    expected_bytes[expected_bytes.size() - 1].run_end = 1'b1;
  endfunction

  // ------------------------------------------------------------------------
  // checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    // keep the log short if the block is badly off
    if (mismatches <= 40) begin
      $display("mismatch on %s: got %0h, want %0h at %0t", field, got, want, $time);
    end
  endtask

  // every result handshake consumes the oldest expected byte
  always @(posedge clk) begin : result_check
    framed_byte_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected byte", out_tdata, 8'h00);
      end else begin
        want = expected_bytes.pop_front();
        if (out_tdata !== want.octet) begin
          report_mismatch("out_byte", out_tdata, want.octet);
        end
        if (out_tuser[1:0] !== want.kind) begin
          report_mismatch("byte_kind", {6'd0, out_tuser[1:0]}, {6'd0, want.kind});
        end
        if (out_tlast !== want.run_end) begin
          report_mismatch("run_end", {7'd0, out_tlast}, {7'd0, want.run_end});
        end
        if (out_tuser[2] !== want.frame_end) begin
          report_mismatch("frame_end", {7'd0, out_tuser[2]}, {7'd0, want.frame_end});
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // result sink: random stalls per result, plus the long hold-off on demand
  // ------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, out_gap_max);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      // take one byte, or leave early when a hold-off comes in while idle
      do @(posedge clk);
      while (!(out_tvalid === 1'b1 && rst_n === 1'b1) && hold_cycles == 0);
    end
  end

  // ------------------------------------------------------------------------
  // request side
  // ------------------------------------------------------------------------

  // offer one request after a random gap; valid stays high on return so that
  // a back-to-back request follows without a bubble
  task automatic offer_request(input logic [7:0] data, input logic first,
                               input logic last, input logic empty);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tlast  <= last;
    in_tuser  <= {empty, first};
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_stuffing(data, first, last, empty);
    requests_sent++;
  endtask

  // drop valid and wait until every predicted byte has come out
  task automatic wait_drained();
    if (in_tvalid !== 1'b0) begin
      in_tvalid <= 1'b0;
    end
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // write both markers while the block is idle
  task automatic set_markers(input logic [7:0] flag_b, input logic [7:0] escape_b);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_FLAG;
    cfg_wdata <= flag_b;
    @(posedge clk);
    cfg_addr  <= REG_ESCAPE;
    cfg_wdata <= escape_b;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    flag_reg   = flag_b;
    escape_reg = escape_b;
  endtask

  // content byte with a heavy bias toward the current markers
  function automatic logic [7:0] draw_data_byte();
    case ($urandom_range(0, 7))
      0, 1:    return flag_reg;
      2:       return escape_reg;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic offer_frame(input int len, input logic open_mark, input logic close_mark);
    for (int i = 0; i < len; i++) begin
      offer_request(draw_data_byte(), open_mark && i == 0, close_mark && i == len - 1, 1'b0);
    end
  endtask

  // mostly complete frames, the rest empty, abandoned, headless or raw noise
  task automatic run_frame_mix(input int count);
    int stop_at;
    int pick;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        offer_frame($urandom_range(1, 8), 1'b1, 1'b1);
      end else if (pick == 13) begin
        // empty frame with random don't-care fields
        offer_request(8'($urandom_range(0, 255)), 1'($urandom), 1'($urandom), 1'b1);
      end else if (pick == 14) begin
        offer_frame($urandom_range(1, 4), 1'b1, 1'b0);
      end else if (pick == 15) begin
        offer_frame($urandom_range(1, 4), 1'b0, 1'b1);
      end else begin
        offer_request(8'($urandom_range(0, 255)), 1'($urandom), 1'($urandom),
                      1'($urandom_range(0, 3) == 0));
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // reset markers: byte extremes, marker bytes, empty frames, broken frames
  task automatic test_default_markers();
    offer_request(8'h00, 1'b1, 1'b1, 1'b0);
    offer_request(8'hFF, 1'b1, 1'b1, 1'b0);
    // one frame with a flag byte and an escape byte in the content
    offer_request(FLAG_RESET, 1'b1, 1'b0, 1'b0);
    offer_request(ESCAPE_RESET, 1'b0, 1'b0, 1'b0);
    offer_request(8'h5A, 1'b0, 1'b1, 1'b0);
    // empty frames, ignored fields at both extremes
    offer_request(8'hFF, 1'b1, 1'b1, 1'b1);
    offer_request(8'h00, 1'b0, 1'b0, 1'b1);
    // first mark inside an unfinished frame restarts it
    offer_request(8'h11, 1'b1, 1'b0, 1'b0);
    offer_request(8'h22, 1'b0, 1'b0, 1'b0);
    offer_request(8'h33, 1'b1, 1'b0, 1'b0);
    offer_request(FLAG_RESET, 1'b0, 1'b1, 1'b0);
    // content outside a frame, later closed by a last mark
    offer_request(8'hA5, 1'b0, 1'b0, 1'b0);
    offer_request(8'h5A, 1'b0, 1'b1, 1'b0);
    // empty frame abandons a partial frame
    offer_request(8'h77, 1'b1, 1'b0, 1'b0);
    offer_request(8'h00, 1'b0, 1'b0, 1'b1);
    // longest run: flag, escape, content, flag, trailer
    offer_request(ESCAPE_RESET, 1'b1, 1'b1, 1'b0);
  endtask

  // flag and escape the same byte: a matching content byte gets one escape
  task automatic test_equal_markers();
    set_markers(8'h7E, 8'h7E);
    offer_request(8'h7E, 1'b1, 1'b0, 1'b0);
    offer_request(8'h7D, 1'b0, 1'b0, 1'b0);
    offer_request(8'h7E, 1'b0, 1'b1, 1'b0);
    offer_request(8'h7E, 1'b0, 1'b0, 1'b1);
  endtask

  // markers at the ends of their range, both ways round
  task automatic test_marker_extremes();
    set_markers(8'h00, 8'hFF);
    offer_request(8'h00, 1'b1, 1'b0, 1'b0);
    offer_request(8'hFF, 1'b0, 1'b1, 1'b0);
    set_markers(8'hFF, 8'h00);
    offer_request(8'hFF, 1'b1, 1'b1, 1'b0);
    offer_request(8'h00, 1'b1, 1'b1, 1'b0);
  endtask

  // random traffic under several marker settings, extremes among them
  task automatic test_random_frames();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        1: begin
          flag_reg = 8'($urandom_range(0, 255));
          set_markers(flag_reg, flag_reg);
        end
        2: set_markers(8'h00, 8'hFF);
        3: set_markers(8'hFF, 8'h00);
        default: set_markers(FLAG_RESET, ESCAPE_RESET);
      endcase
      // alternate sparse and dense sender traffic
      in_gap_max = (phase % 2 == 0) ? 16 : 3;
      run_frame_mix(32);
    end
    in_gap_max = 16;
  endtask

  // receiver holds off while the sender keeps offering, then the sender
  // pauses until the block has flushed everything
  task automatic test_receiver_hold();
    in_gap_max  = 0;
    hold_cycles = 150;
    run_frame_mix(40);
    wait_drained();
    in_gap_max = 16;
  endtask

  // both sides at full rate
  task automatic test_full_rate();
    in_gap_max  = 0;
    out_gap_max = 0;
    run_frame_mix(40);
    wait_drained();
    in_gap_max  = 16;
    out_gap_max = 16;
  endtask

  // ------------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------------
  initial begin
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    in_tuser   <= '0;
    cfg_wr_en  <= 1'b0;
    cfg_addr   <= REG_FLAG;
    cfg_wdata  <= '0;
    rst_n      <= 1'b0;
    flag_reg   = FLAG_RESET;
    escape_reg = ESCAPE_RESET;
    parity_run = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_default_markers();
    test_equal_markers();
    test_marker_extremes();
    test_random_frames();
    test_receiver_hold();
    test_full_rate();

    // let any stray byte show up before the verdict
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("byte_stuff_framer_with_parity verification clean");
    end else begin
      $display("byte_stuff_framer_with_parity verification failed");
    end
    $finish;
  end

  // run limit, well above the slowest correct run
  initial begin
    #2_400_000;
    $display("byte_stuff_framer_with_parity verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/bsfp_pkg.sv
rtl/core/byte_stuff_framer_with_parity.sv
bench/byte_stuff_framer_with_parity_tb.sv
